// ===== sv/ljqm_pkg.sv =====
// Package for the latency jitter quality monitor.
// Payload structs, widths, quality constants and the sequencer state type.
// No dependencies.
package ljqm_pkg;

	localparam int WINDOW   = 60;
	localparam int LAT_W    = 16;
	localparam int LOSS_W   = 11;
	localparam int JIT_W    = 16;
	localparam int QUAL_W   = 7;
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W    = LAT_W + $clog2(WINDOW);
	localparam int DIVC_W   = $clog2(SUM_W + 1);
	localparam int PEN_W    = 10;

	localparam logic [CNT_W-1:0]  WINDOW_CNT  = CNT_W'(WINDOW);
	localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(WINDOW - 1);

	// Quality arithmetic, in input units (1/16 ms, 1/16 %).
	localparam logic [LAT_W-1:0]  LAT_THRESH  = 16'd800;  // 50 ms
	localparam logic [11:0]       LAT_CAP_X   = 12'd200;  // 40 steps of 5 ms, in 1 ms units
	localparam logic [7:0]        DIV5_RECIP  = 8'd205;   // x*205>>10 == x/5 for x < 200
	localparam logic [5:0]        LAT_PEN_MAX = 6'd40;
	localparam logic [JIT_W-1:0]  JIT_THRESH  = 16'd160;  // 10 ms
	localparam logic [10:0]       JIT_PEN_MAX = 11'd20;
	localparam logic [QUAL_W-1:0] QUAL_MAX    = 7'd100;
	localparam logic [QUAL_W-1:0] QUAL_STEP   = 7'd10;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [LAT_W-1:0]  latency;
		logic [LOSS_W-1:0] loss_rate;
	} ljqm_req_t;

	typedef struct packed {
		logic [JIT_W-1:0]  jitter;
		logic [QUAL_W-1:0] quality;
		logic              quality_changed;
	} ljqm_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_RD_NEXT,
		ST_RD_NEW,
		ST_SUM,
		ST_DIV,
		ST_PEN,
		ST_FIN
	} ljqm_state_t;

endpackage

// ===== sv/ljqm_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, SUM_W quotient bits.
// Depends on ljqm_pkg for widths.
module ljqm_serial_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ljqm_pkg::SUM_W-1:0]  dividend,
	input  logic [ljqm_pkg::CNT_W-1:0]  divisor,
	output logic                        done,
	output logic [ljqm_pkg::SUM_W-1:0]  quotient
);

	logic [ljqm_pkg::SUM_W-1:0]  dvd_q;
	logic [ljqm_pkg::CNT_W-1:0]  rem_q;
	logic [ljqm_pkg::CNT_W-1:0]  dsr_q;
	logic [ljqm_pkg::DIVC_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ljqm_pkg::CNT_W:0]    trial;
	logic                        qbit;

	assign trial = {rem_q, dvd_q[ljqm_pkg::SUM_W-1]};
	assign qbit  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ljqm_pkg::DIVC_W'(ljqm_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ljqm_pkg::DIVC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ljqm_pkg::SUM_W-2:0], qbit};
			rem_q <= qbit ? ljqm_pkg::CNT_W'(trial - {1'b0, dsr_q})
			              : trial[ljqm_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== sv/latency_jitter_quality_monitor_unit.sv =====
// Latency jitter quality monitor, top level: sample ring, difference sum,
// sequencer, penalty logic and output register.
// Depends on ljqm_pkg and ljqm_serial_div.
//
//   channel | handshake            | payload            | moves
//   --------+----------------------+--------------------+---------------------------
//   in      | in_valid / in_ready  | in_req  (req_t)    | record or clear request
//   out     | out_valid / out_ready| out_res (res_t)    | jitter, quality, change flag
//
// A clear request is taken in the idle state and gives no result. A record
// request runs from accept to the next accept through idle, three ring reads,
// sum update, the bit-serial jitter divider (22 quotient steps, then done),
// penalty and score steps; the result is registered in the score step.
// With fewer than two samples the divider is skipped.
// Reset (arst_n low) empties the history, sets jitter 0 and reference 100.
// A result waits in the output register; the next request is taken meanwhile,
// and the sequencer only holds in its last step if that register is still full.
module latency_jitter_quality_monitor_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ljqm_pkg::ljqm_req_t in_req,
	output logic                out_valid,
	input  logic                out_ready,
	output ljqm_pkg::ljqm_res_t out_res
);

	// ---------------------------------------------------------------
	// State
	// ---------------------------------------------------------------
	ljqm_pkg::ljqm_state_t state_q, state_nxt;

	logic [ljqm_pkg::CNT_W-1:0]  count_q;
	logic [ljqm_pkg::SLOT_W-1:0] slot_q;
	logic [ljqm_pkg::SUM_W-1:0]  sum_q;
	logic [ljqm_pkg::JIT_W-1:0]  jitter_q;
	logic [ljqm_pkg::QUAL_W-1:0] ref_q;

	// Request capture
	logic [ljqm_pkg::LAT_W-1:0]  lat_q;
	logic [ljqm_pkg::LOSS_W-1:0] loss_q;
	logic [ljqm_pkg::LAT_W-1:0]  old_q;     // oldest sample when the window is full

	// Ring memory, registered read
	logic [ljqm_pkg::LAT_W-1:0]  ring_mem [ljqm_pkg::WINDOW];
	logic [ljqm_pkg::LAT_W-1:0]  rd_q;
	logic [ljqm_pkg::SLOT_W-1:0] rd_addr;
	logic                        ring_we;

	// Penalty sum and output register
	logic [ljqm_pkg::PEN_W-1:0]  pen_q;
	logic                        out_valid_q;
	ljqm_pkg::ljqm_res_t         out_q;

	// Sequencer controls
	logic accept;
	logic div_start;
	logic div_done;
	logic [ljqm_pkg::SUM_W-1:0] quot;
	logic out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// ---------------------------------------------------------------
	// Slot neighbors (modulo WINDOW)
	// ---------------------------------------------------------------
	logic [ljqm_pkg::SLOT_W-1:0] slot_next, slot_prev;
	assign slot_next = (slot_q == ljqm_pkg::LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign slot_prev = (slot_q == '0) ? ljqm_pkg::LAST_SLOT : slot_q - 1'b1;

	// ---------------------------------------------------------------
	// Difference arithmetic
	// ---------------------------------------------------------------
	logic [ljqm_pkg::LAT_W-1:0] drop_diff;   // |next - oldest|
	logic [ljqm_pkg::LAT_W-1:0] add_diff;    // |new - newest|
	logic [ljqm_pkg::SUM_W-1:0] sum_added;
	logic [ljqm_pkg::CNT_W-1:0] count_inc;
	logic                       window_full;

	assign window_full = (count_q >= ljqm_pkg::WINDOW_CNT);
	assign drop_diff   = (rd_q > old_q) ? rd_q - old_q : old_q - rd_q;
	assign add_diff    = (lat_q > rd_q) ? lat_q - rd_q : rd_q - lat_q;
	assign sum_added   = (count_q != '0)
	                   ? sum_q + ljqm_pkg::SUM_W'(add_diff) : sum_q;
	assign count_inc   = count_q + 1'b1;

	// ---------------------------------------------------------------
	// Sequencer: next state and controls
	// ---------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		ring_we   = 1'b0;
		rd_addr   = slot_q;
		unique case (state_q)
			ljqm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_req.cmd == ljqm_pkg::CMD_RECORD) begin
					state_nxt = ljqm_pkg::ST_RD_OLD;
				end
			end
			ljqm_pkg::ST_RD_OLD: begin
				rd_addr   = slot_q;        // oldest sample
				state_nxt = ljqm_pkg::ST_RD_NEXT;
			end
			ljqm_pkg::ST_RD_NEXT: begin
				rd_addr   = slot_next;     // its successor
				state_nxt = ljqm_pkg::ST_RD_NEW;
			end
			ljqm_pkg::ST_RD_NEW: begin
				rd_addr   = slot_prev;     // newest sample
				state_nxt = ljqm_pkg::ST_SUM;
			end
			ljqm_pkg::ST_SUM: begin
				ring_we = 1'b1;
				if (count_inc >= ljqm_pkg::CNT_W'(2)) begin
					div_start = 1'b1;
					state_nxt = ljqm_pkg::ST_DIV;
				end else begin
					state_nxt = ljqm_pkg::ST_PEN;
				end
			end
			ljqm_pkg::ST_DIV: begin
				if (div_done) begin
					state_nxt = ljqm_pkg::ST_PEN;
				end
			end
			ljqm_pkg::ST_PEN: begin
				state_nxt = ljqm_pkg::ST_FIN;
			end
			ljqm_pkg::ST_FIN: begin
				if (out_free) begin
					state_nxt = ljqm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = ljqm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ljqm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Ring memory
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot_q] <= lat_q;
		end
		rd_q <= ring_mem[rd_addr];
	end

	// ---------------------------------------------------------------
	// Jitter divider
	// ---------------------------------------------------------------
	ljqm_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_added),
		.divisor  (count_q),       // new count minus one
		.done     (div_done),
		.quotient (quot)
	);

	// ---------------------------------------------------------------
	// History state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			slot_q   <= '0;
			sum_q    <= '0;
			jitter_q <= '0;
		end else begin
			if (accept && in_req.cmd == ljqm_pkg::CMD_CLEAR) begin
				count_q <= '0;
				slot_q  <= '0;
				sum_q   <= '0;
			end
			// Full window: drop the oldest sample's difference.
			if (state_q == ljqm_pkg::ST_RD_NEW && window_full) begin
				sum_q   <= (sum_q >= ljqm_pkg::SUM_W'(drop_diff))
				         ? sum_q - ljqm_pkg::SUM_W'(drop_diff) : '0;
				count_q <= ljqm_pkg::WINDOW_CNT - 1'b1;
			end
			if (state_q == ljqm_pkg::ST_SUM) begin
				sum_q   <= sum_added;
				count_q <= count_inc;
				slot_q  <= slot_next;
			end
			if (state_q == ljqm_pkg::ST_DIV && div_done) begin
				jitter_q <= (quot > ljqm_pkg::SUM_W'({ljqm_pkg::JIT_W{1'b1}}))
				          ? {ljqm_pkg::JIT_W{1'b1}} : quot[ljqm_pkg::JIT_W-1:0];
			end
		end
	end

	// Request payload; old_q takes the oldest sample as it comes off the read
	always_ff @(posedge clk) begin
		if (accept) begin
			lat_q  <= in_req.latency;
			loss_q <= in_req.loss_rate;
		end
		if (state_q == ljqm_pkg::ST_RD_NEXT) begin
			old_q <= rd_q;
		end
	end

	// ---------------------------------------------------------------
	// Penalties
	// lat:     (lat-800)/80 = ((lat-800)>>4)/5, capped at 40
	// jitter:  (jit-160)>>5, capped at 20
	// loss:    loss>>2
	// ---------------------------------------------------------------
	logic [ljqm_pkg::LAT_W-1:0] lat_x;
	logic [11:0]                lat_ms;
	logic [15:0]                lat_prod;
	logic [5:0]                 lat_pen;
	logic [ljqm_pkg::JIT_W-1:0] jit_x;
	logic [10:0]                jit_steps;
	logic [4:0]                 jit_pen;
	logic [8:0]                 loss_pen;

	assign lat_x    = lat_q - ljqm_pkg::LAT_THRESH;
	assign lat_ms   = lat_x[ljqm_pkg::LAT_W-1:4];
	assign lat_prod = lat_ms[7:0] * ljqm_pkg::DIV5_RECIP;

	always_comb begin
		if (lat_q <= ljqm_pkg::LAT_THRESH) begin
			lat_pen = '0;
		end else if (lat_ms >= ljqm_pkg::LAT_CAP_X) begin
			lat_pen = ljqm_pkg::LAT_PEN_MAX;
		end else begin
			lat_pen = lat_prod[15:10];
		end
	end

	assign jit_x     = jitter_q - ljqm_pkg::JIT_THRESH;
	assign jit_steps = jit_x[ljqm_pkg::JIT_W-1:5];

	always_comb begin
		if (jitter_q <= ljqm_pkg::JIT_THRESH) begin
			jit_pen = '0;
		end else if (jit_steps >= ljqm_pkg::JIT_PEN_MAX) begin
			jit_pen = ljqm_pkg::JIT_PEN_MAX[4:0];
		end else begin
			jit_pen = jit_steps[4:0];
		end
	end

	assign loss_pen = loss_q[ljqm_pkg::LOSS_W-1:2];

	always_ff @(posedge clk) begin
		if (state_q == ljqm_pkg::ST_PEN) begin
			pen_q <= ljqm_pkg::PEN_W'(lat_pen) + ljqm_pkg::PEN_W'(jit_pen)
			       + ljqm_pkg::PEN_W'(loss_pen);
		end
	end

	// ---------------------------------------------------------------
	// Score, clamp and change detection
	// ---------------------------------------------------------------
	logic [ljqm_pkg::QUAL_W-1:0] qual;
	logic [ljqm_pkg::QUAL_W:0]   qual_hi;
	logic [ljqm_pkg::QUAL_W:0]   ref_hi;
	logic                        changed;

	assign qual    = (pen_q >= ljqm_pkg::PEN_W'(ljqm_pkg::QUAL_MAX))
	               ? '0 : ljqm_pkg::QUAL_MAX - pen_q[ljqm_pkg::QUAL_W-1:0];
	assign qual_hi = {1'b0, qual} + {1'b0, ljqm_pkg::QUAL_STEP};
	assign ref_hi  = {1'b0, ref_q} + {1'b0, ljqm_pkg::QUAL_STEP};
	assign changed = ({1'b0, qual} > ref_hi) || ({1'b0, ref_q} > qual_hi);

	logic fin_fire;
	assign fin_fire = (state_q == ljqm_pkg::ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= ljqm_pkg::QUAL_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
				if (changed) begin
					ref_q <= qual;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_q.jitter          <= jitter_q;
			out_q.quality         <= qual;
			out_q.quality_changed <= changed;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule
